// ===== hw/rtl/sgsi_pkg.sv =====
// Shared constants, codes and control types of the sorted group slice indexer.
`timescale 1ns / 1ps

package sgsi_pkg;

    // Store geometry and field widths
    localparam int GROUP_CAPACITY = 1024;
    localparam int GROUP_BITS     = $clog2(GROUP_CAPACITY);
    localparam int CUR_W          = GROUP_BITS + 1;
    localparam int ROW_BITS       = 20;
    localparam int CNT_W          = ROW_BITS + 1;
    localparam int VALUE_W        = 32;
    localparam int EPOCH_W        = 8;

    // Operation codes of an input item
    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_PUSH  = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    // Status codes of a result item
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_POS_UNSORTED = 3'd1,
        ST_POS_SPLIT    = 3'd2,
        ST_NEG_UNSORTED = 3'd3,
        ST_NEG_SPLIT    = 3'd4,
        ST_DISABLED     = 3'd5,
        ST_CAPACITY     = 3'd6
    } t_status;

    // One store entry: epoch tag marks it valid for the current table
    typedef struct packed {
        logic [EPOCH_W-1:0]  epoch;
        logic [ROW_BITS-1:0] offset;
        logic [CNT_W-1:0]    size;
    } t_entry;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic clear_step;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;
        logic wrap;
        logic out_busy;
    } t_dp_status;

endpackage

// ===== hw/rtl/sgsi_in_if.sv =====
// Input channel of the indexer: one table operation per transfer.
`timescale 1ns / 1ps

interface sgsi_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          op;
    logic signed [31:0]  row_group;
    logic signed [31:0]  query_group;

    modport source (output valid, output op, output row_group, output query_group,
                    input ready);
    modport sink   (input valid, input op, input row_group, input query_group,
                    output ready);
endinterface

// ===== hw/rtl/sgsi_out_if.sv =====
// Output channel of the indexer: one result per transfer.
`timescale 1ns / 1ps

interface sgsi_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [19:0] slice_offset;
    logic [20:0] slice_size;

    modport source (output valid, output status, output slice_offset, output slice_size,
                    input ready);
    modport sink   (input valid, input status, input slice_offset, input slice_size,
                    output ready);
endinterface

// ===== hw/rtl/sgsi_ctrl.sv =====
// Controller state machine: store clearing sweep, accept, execute.
`timescale 1ns / 1ps

module sgsi_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sgsi_pkg::t_dp_status  i_status,
    output sgsi_pkg::t_cmd        o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode commands and next state
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_in_ready       = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_status.out_busy) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_status.wrap ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Hold state; sweep the store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_transfer_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted item did not move to execute");

    a_wrap_to_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec && i_status.wrap) |=> (r_state == S_CLEAR))
        else $error("epoch wrap did not start a clearing sweep");

    a_no_exec_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && i_status.out_busy) |=> (r_state == S_EXEC))
        else $error("execute left while result register was busy");
`endif

endmodule

// ===== hw/rtl/sgsi_datapath.sv =====
// Datapath: order checks, group store with epoch tags, error and result registers.
`timescale 1ns / 1ps

module sgsi_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sgsi_pkg::t_cmd        i_cmd,
    output sgsi_pkg::t_dp_status  o_status,
    input  logic [1:0]            i_in_op,
    input  logic signed [31:0]    i_in_row_group,
    input  logic signed [31:0]    i_in_query_group,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_out_status,
    output logic [19:0]           o_out_slice_offset,
    output logic [20:0]           o_out_slice_size
);

    localparam int GB  = sgsi_pkg::GROUP_BITS;
    localparam int RB  = sgsi_pkg::ROW_BITS;
    localparam int CW  = sgsi_pkg::CNT_W;
    localparam int UW  = sgsi_pkg::CUR_W;
    localparam int VW  = sgsi_pkg::VALUE_W;
    localparam int EW  = sgsi_pkg::EPOCH_W;

    // Group store
    sgsi_pkg::t_entry r_mem [sgsi_pkg::GROUP_CAPACITY];
    sgsi_pkg::t_entry r_rd_entry;

    // Captured item
    sgsi_pkg::t_op          r_op;
    logic signed [VW-1:0]   r_row;
    logic signed [VW-1:0]   r_query;

    // Table state
    logic [CW-1:0]          r_row_cnt,  n_row_cnt;
    logic [UW-1:0]          r_cur,      n_cur;
    logic signed [VW-1:0]   r_prev,     n_prev;
    logic signed [VW-1:0]   r_last_pos, n_last_pos;
    logic signed [VW-1:0]   r_last_neg, n_last_neg;
    logic                   r_first,    n_first;
    sgsi_pkg::t_status      r_sticky,   n_sticky;
    logic [EW-1:0]          r_epoch,    n_epoch;
    logic                   r_cache_en;
    logic [GB-1:0]          r_clr_addr;

    // Result register
    logic                   r_out_valid;
    sgsi_pkg::t_status      r_out_status;
    logic [RB-1:0]          r_out_offset;
    logic [CW-1:0]          r_out_size;

    // Execute-stage signals
    sgsi_pkg::t_status      res_status;
    logic [RB-1:0]          res_offset;
    logic [CW-1:0]          res_size;
    logic                   push_wr;
    sgsi_pkg::t_entry       wr_entry;
    logic                   mem_we;
    logic [GB-1:0]          mem_waddr;
    sgsi_pkg::t_entry       mem_wdata;
    logic [GB-1:0]          rd_addr;
    logic                   hit;
    logic [UW-1:0]          row_grp_ext;

    // Order check signals
    logic                   v_neg;
    logic signed [VW-1:0]   chk_prev;
    logic                   prev_neg;
    logic signed [VW-1:0]   chk_lp;
    logic signed [VW-1:0]   chk_ln;
    sgsi_pkg::t_status      chk_err;

    assign hit         = (r_rd_entry.epoch == r_epoch);
    assign v_neg       = r_row[VW-1];
    assign row_grp_ext = {1'b0, r_row[GB-1:0]};

    // Seed or advance the last seen positive and negative values
    always_comb begin
        if (!r_first) begin
            chk_prev = r_row;
            chk_lp   = v_neg ? '1 : r_row;
            chk_ln   = v_neg ? r_row : '0;
        end else begin
            chk_prev = r_prev;
            chk_lp   = r_prev[VW-1] ? r_last_pos : r_prev;
            chk_ln   = r_prev[VW-1] ? r_prev : r_last_neg;
        end
    end

    assign prev_neg = chk_prev[VW-1];

    // Classify the order of the pushed value
    always_comb begin
        chk_err = sgsi_pkg::ST_OK;
        if (!v_neg) begin
            if (chk_lp > r_row) begin
                chk_err = sgsi_pkg::ST_POS_UNSORTED;
            end else if (chk_lp == r_row && prev_neg) begin
                chk_err = sgsi_pkg::ST_POS_SPLIT;
            end
        end else begin
            if (chk_ln < r_row) begin
                chk_err = sgsi_pkg::ST_NEG_UNSORTED;
            end else if (chk_ln == r_row && !prev_neg) begin
                chk_err = sgsi_pkg::ST_NEG_SPLIT;
            end
        end
    end

    // Execute one operation
    always_comb begin
        n_row_cnt  = r_row_cnt;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_last_pos = r_last_pos;
        n_last_neg = r_last_neg;
        n_first    = r_first;
        n_sticky   = r_sticky;
        n_epoch    = r_epoch;
        res_status = sgsi_pkg::ST_OK;
        res_offset = '0;
        res_size   = '0;
        push_wr    = 1'b0;
        wr_entry.epoch  = r_epoch;
        wr_entry.offset = (row_grp_ext != r_cur) ? r_row_cnt[RB-1:0]
                        : (hit ? r_rd_entry.offset : '0);
        wr_entry.size   = (hit ? r_rd_entry.size : '0) + CW'(1);
        unique case (r_op)
            sgsi_pkg::OP_BEGIN: begin
                n_row_cnt  = '0;
                n_cur      = UW'(sgsi_pkg::GROUP_CAPACITY);
                n_prev     = '0;
                n_last_pos = '1;
                n_last_neg = '0;
                n_first    = 1'b0;
                n_sticky   = sgsi_pkg::ST_OK;
                n_epoch    = (r_epoch == '1) ? EW'(1) : r_epoch + EW'(1);
            end
            sgsi_pkg::OP_PUSH: begin
                if (r_sticky != sgsi_pkg::ST_OK) begin
                    res_status = r_sticky;
                end else if (!r_cache_en) begin
                    n_sticky   = sgsi_pkg::ST_DISABLED;
                    res_status = sgsi_pkg::ST_DISABLED;
                end else begin
                    n_last_pos = chk_lp;
                    n_last_neg = chk_ln;
                    n_first    = 1'b1;
                    n_prev     = r_row;
                    if (chk_err != sgsi_pkg::ST_OK) begin
                        n_sticky   = chk_err;
                        res_status = chk_err;
                    end else if ((!v_neg && r_row >= VW'(sgsi_pkg::GROUP_CAPACITY))
                                 || r_row_cnt[RB]) begin
                        n_sticky   = sgsi_pkg::ST_CAPACITY;
                        res_status = sgsi_pkg::ST_CAPACITY;
                    end else begin
                        n_row_cnt = r_row_cnt + CW'(1);
                        if (!v_neg) begin
                            push_wr = 1'b1;
                            n_cur   = row_grp_ext;
                        end
                    end
                end
            end
            sgsi_pkg::OP_QUERY: begin
                if (r_sticky != sgsi_pkg::ST_OK) begin
                    res_status = r_sticky;
                end else if (!r_cache_en) begin
                    res_status = sgsi_pkg::ST_DISABLED;
                end else if (!r_query[VW-1] && r_query < VW'(sgsi_pkg::GROUP_CAPACITY)
                             && hit) begin
                    res_offset = r_rd_entry.offset;
                    res_size   = r_rd_entry.size;
                end
            end
            default: begin
                res_status = sgsi_pkg::ST_OK;
            end
        endcase
    end

    // Select the store port between the clearing sweep and a push
    assign mem_we    = i_cmd.clear_step || (i_cmd.exec && push_wr);
    assign mem_waddr = i_cmd.clear_step ? r_clr_addr : r_row[GB-1:0];
    assign mem_wdata = i_cmd.clear_step ? '0 : wr_entry;
    assign rd_addr   = (sgsi_pkg::t_op'(i_in_op) == sgsi_pkg::OP_QUERY)
                     ? i_in_query_group[GB-1:0] : i_in_row_group[GB-1:0];

    // Store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.capture) begin
            r_rd_entry <= r_mem[rd_addr];
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= sgsi_pkg::t_op'(i_in_op);
            r_row   <= i_in_row_group;
            r_query <= i_in_query_group;
        end
    end

    // Table state, configuration and sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt  <= '0;
            r_cur      <= UW'(sgsi_pkg::GROUP_CAPACITY);
            r_prev     <= '0;
            r_last_pos <= '1;
            r_last_neg <= '0;
            r_first    <= 1'b0;
            r_sticky   <= sgsi_pkg::ST_OK;
            r_epoch    <= EW'(1);
            r_cache_en <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_row_cnt  <= n_row_cnt;
                r_cur      <= n_cur;
                r_prev     <= n_prev;
                r_last_pos <= n_last_pos;
                r_last_neg <= n_last_neg;
                r_first    <= n_first;
                r_sticky   <= n_sticky;
                r_epoch    <= n_epoch;
            end
            if (i_cfg_we) begin
                r_cache_en <= i_cfg_wdata;
            end
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + GB'(1);
            end
        end
    end

    // Result register: load on execute, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_status <= res_status;
            r_out_offset <= res_offset;
            r_out_size   <= res_size;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_status       = r_out_status;
    assign o_out_slice_offset = r_out_offset;
    assign o_out_slice_size   = r_out_size;

    assign o_status.clear_last = (r_clr_addr == '1);
    assign o_status.wrap       = (r_op == sgsi_pkg::OP_BEGIN) && (r_epoch == '1);
    assign o_status.out_busy   = r_out_valid && !i_out_ready;

`ifndef SYNTH
    a_sticky_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sticky != sgsi_pkg::ST_OK && !(i_cmd.exec && r_op == sgsi_pkg::OP_BEGIN))
        |=> $stable(r_sticky))
        else $error("sticky error changed without a new table");

    a_row_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_cnt <= (CW'(1) << RB))
        else $error("row counter passed the row limit");

    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("epoch reached the cleared tag value");
`endif

endmodule

// ===== hw/rtl/sorted_group_slice_indexer_core.sv =====
// Top level of the sorted group slice indexer: controller plus datapath.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+---------------------------------------
//  i_in     | in  | valid / ready   | op, row_group, query_group
//  o_out    | out | valid / ready   | status, slice_offset, slice_size
//  i_cfg_*  | in  | write enable    | cache_enabled (1 bit)
//
// An item's store entry is read into a registered read port at the accept edge;
// execute then writes the store and the result register once the result
// register is free, so a new item is accepted only after the last has executed.
// After reset a clearing sweep writes every store entry; every 255th new table
// wraps the epoch tag and runs the same sweep. No item is accepted during a
// sweep. A result not taken holds the next item in execute.
`timescale 1ns / 1ps

module sorted_group_slice_indexer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sgsi_in_if.sink     i_in,
    sgsi_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    sgsi_pkg::t_cmd       cmd;
    sgsi_pkg::t_dp_status dp_status;

    // Sequence the store sweep and each transfer
    sgsi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    // Checks, store and result register
    sgsi_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (dp_status),
        .i_in_op            (i_in.op),
        .i_in_row_group     (i_in.row_group),
        .i_in_query_group   (i_in.query_group),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_out_valid        (o_out.valid),
        .i_out_ready        (o_out.ready),
        .o_out_status       (o_out.status),
        .o_out_slice_offset (o_out.slice_offset),
        .o_out_slice_size   (o_out.slice_size)
    );

endmodule
